// ===== sv/packed_pixel_unpacker_diff_top_macros.svh =====
// Assertion macros shared by the pixel unpacker modules.
`ifndef PACKED_PIXEL_UNPACKER_DIFF_TOP_MACROS_SVH
`define PACKED_PIXEL_UNPACKER_DIFF_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PPUD_ASSERT_CK(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);
`define PPUD_ASSERT(lbl, prop, msg) \
  `PPUD_ASSERT_CK(lbl, clk, rst_n, prop, msg)
`else
`define PPUD_ASSERT_CK(lbl, ck, rstn, prop, msg)
`define PPUD_ASSERT(lbl, prop, msg)
`endif
`endif

// ===== sv/ppud_pkg.sv =====
// Types and constants shared by the pixel unpacker modules.
package ppud_pkg;

  typedef struct packed {
    logic       packing;
    logic       big_endian;
    logic [1:0] data_depth;
  } cfg_t;

  typedef struct packed {
    logic        frame_start;
    logic        mode;
    logic [15:0] prev_pixel;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic        error;
    logic [15:0] pixel;
  } res_t;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  localparam logic [1:0] REG_PACKING    = 2'd0;
  localparam logic [1:0] REG_BIG_ENDIAN = 2'd1;
  localparam logic [1:0] REG_DATA_DEPTH = 2'd2;

  localparam logic [1:0] DEPTH_NATIVE = 2'd0;
  localparam logic [1:0] DEPTH_12     = 2'd1;
  localparam logic [1:0] DEPTH_16     = 2'd2;

  localparam logic [15:0] PIX12_MAX = 16'd4095;

endpackage

// ===== sv/packed_pixel_unpacker_diff_top.sv =====
// An accepted item waits in the input register; a pixel it completes goes to the result register.
// Throughput: one item per cycle while out_tready stays high.
// The input register and the result register each take one stage of the pipe.
// Synchronous active-low reset clears the byte phase and the held byte and
// loads the registers with packing 0, big_endian 0 and data_depth twelve bits.
`include "packed_pixel_unpacker_diff_top_macros.svh"
module packed_pixel_unpacker_diff_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // data_byte[7:0], prev_pixel[23:8]
  input  logic [1:0]  in_tuser,   // mode[0], frame_start[1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // pixel[15:0]
  output logic        out_tuser,  // error[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data
);

  ppud_pkg::cfg_t     cfg;
  ppud_pkg::in_item_t s1_item_r;
  logic               s1_valid_r;
  logic               s1_valid_nxt;
  logic               out_free;
  logic               consume;
  logic               res_valid;
  ppud_pkg::res_t     res;
  ppud_pkg::res_t     out_res_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               in_acc;

  assign cfg_ready = 1'b1;

  ppud_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign consume   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || consume;
  assign in_acc    = in_tvalid && in_tready;

  ppud_unpack u_unpack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .item      (s1_item_r),
    .step      (consume),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (consume) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (consume && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.data_byte   <= in_tdata[7:0];
      s1_item_r.prev_pixel  <= in_tdata[23:8];
      s1_item_r.mode        <= in_tuser[0];
      s1_item_r.frame_start <= in_tuser[1];
    end
    if (consume && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.pixel;
  assign out_tuser  = out_res_r.error;

  `PPUD_ASSERT(a_s1_held, s1_valid_r && !out_free |=> s1_valid_r, "item dropped from the input register")

endmodule

// ===== sv/ppud_cfg.sv =====
// Configuration register file of the pixel unpacker.
module ppud_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [1:0]        wr_index,
  input  logic [1:0]        wr_data,
  output ppud_pkg::cfg_t    cfg
);

  ppud_pkg::cfg_t cfg_r;
  ppud_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        ppud_pkg::REG_PACKING:    cfg_nxt.packing    = wr_data[0];
        ppud_pkg::REG_BIG_ENDIAN: cfg_nxt.big_endian = wr_data[0];
        ppud_pkg::REG_DATA_DEPTH: cfg_nxt.data_depth = wr_data;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.packing    <= 1'b0;
      cfg_r.big_endian <= 1'b0;
      cfg_r.data_depth <= ppud_pkg::DEPTH_12;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/ppud_unpack.sv =====
// Byte phase tracking and pixel decode for one registered item.
`include "packed_pixel_unpacker_diff_top_macros.svh"
module ppud_unpack (
  input  logic               clk,
  input  logic               rst_n,
  input  ppud_pkg::cfg_t     cfg,
  input  ppud_pkg::in_item_t item,
  input  logic               step,
  output logic               res_valid,
  output ppud_pkg::res_t     res
);

  ppud_pkg::phase_t phase_r;
  ppud_pkg::phase_t phase_nxt;
  ppud_pkg::phase_t phase_cur;
  logic [7:0]       held_r;
  logic [7:0]       held_nxt;
  logic [11:0]      val12;
  logic [15:0]      raw_word;
  ppud_pkg::res_t   pk_res;
  ppud_pkg::res_t   res_int;

  function automatic ppud_pkg::res_t pack_conv(input logic [11:0] v12,
                                               input logic [15:0] base,
                                               input logic diff,
                                               input ppud_pkg::cfg_t c);
    logic [15:0] v;
    logic [15:0] shifted;
    logic [16:0] sum;
    ppud_pkg::res_t r;
    shifted = {v12, 4'h0};
    r.error = 1'b0;
    if (c.big_endian) begin
      v = {shifted[7:0], shifted[15:8]};
      r.error = (c.data_depth == ppud_pkg::DEPTH_12);
    end else if (c.data_depth == ppud_pkg::DEPTH_16) begin
      v = shifted;
    end else begin
      v = {4'h0, v12};
    end
    if (diff) begin
      sum = {1'b0, v} + {1'b0, base};
      v = sum[15:0];
      if (c.data_depth == ppud_pkg::DEPTH_12 && v > ppud_pkg::PIX12_MAX) begin
        v = v - ppud_pkg::PIX12_MAX;
      end
    end
    r.pixel = r.error ? 16'h0000 : v;
    return r;
  endfunction

  assign phase_cur = item.frame_start ? ppud_pkg::PH_FIRST : phase_r;

  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      if (cfg.packing) begin
        phase_nxt = (phase_cur == ppud_pkg::PH_FIRST) ? ppud_pkg::PH_SECOND
                                                      : ppud_pkg::PH_FIRST;
      end else begin
        unique case (phase_cur)
          ppud_pkg::PH_SECOND: phase_nxt = ppud_pkg::PH_THIRD;
          ppud_pkg::PH_THIRD:  phase_nxt = ppud_pkg::PH_FIRST;
          default:             phase_nxt = ppud_pkg::PH_SECOND;
        endcase
      end
    end
  end

  always_comb begin
    held_nxt  = held_r;
    res_valid = 1'b0;
    val12     = 12'h000;
    raw_word  = cfg.big_endian ? {held_r, item.data_byte} : {item.data_byte, held_r};
    res_int.error = 1'b0;
    res_int.pixel = 16'h0000;
    if (cfg.packing) begin
      if (phase_cur == ppud_pkg::PH_FIRST) begin
        held_nxt = item.data_byte;
      end else begin
        res_valid     = 1'b1;
        res_int.error = (cfg.data_depth != ppud_pkg::DEPTH_12);
        res_int.pixel = res_int.error ? 16'h0000 : {4'h0, raw_word[15:4]};
      end
    end else begin
      unique case (phase_cur)
        ppud_pkg::PH_SECOND: begin
          val12     = {held_r, item.data_byte[7:4]};
          held_nxt  = item.data_byte;
          res_valid = 1'b1;
        end
        ppud_pkg::PH_THIRD: begin
          val12     = {held_r[3:0], item.data_byte};
          res_valid = 1'b1;
        end
        default: begin
          held_nxt = item.data_byte;
        end
      endcase
      res_int = pk_res;
    end
  end

  assign pk_res = pack_conv(val12, item.prev_pixel, item.mode, cfg);
  assign res    = res_int;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ppud_pkg::PH_FIRST;
      held_r  <= 8'h00;
    end else begin
      phase_r <= phase_nxt;
      if (step) begin
        held_r <= held_nxt;
      end
    end
  end

  `PPUD_ASSERT(a_pk_first_silent, step && !cfg.packing && phase_cur == ppud_pkg::PH_FIRST |-> !res_valid, "first byte of a group gave a pixel")
  `PPUD_ASSERT(a_raw_depth_err, res_valid && cfg.packing && cfg.data_depth != ppud_pkg::DEPTH_12 |-> res.error && res.pixel == 16'h0000, "raw mode without twelve-bit depth not flagged")
  `PPUD_ASSERT(a_be12_err, res_valid && !cfg.packing && cfg.big_endian && cfg.data_depth == ppud_pkg::DEPTH_12 |-> res.error, "big-endian twelve-bit not flagged")

endmodule
